// ----- sv/fcfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcfr_pkg
// Shared default value width and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package fcfr_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic make_g;
    logic div_step;
    logic store;
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic gcd_done;
    logic div_last;
  } status_t;

endpackage

// ----- sv/fcfr_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcfr_in_if / fcfr_out_if
// Valid/ready channels for input value pairs and reduced result pairs.
// ----------------------------------------------------------------------------
interface fcfr_in_if #(
  parameter int unsigned VALUE_WIDTH = fcfr_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] first_value;
  logic signed [VALUE_WIDTH-1:0] second_value;

  modport source (output valid, output first_value, output second_value, input ready);
  modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

interface fcfr_out_if #(
  parameter int unsigned VALUE_WIDTH = fcfr_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] reduced_first;
  logic signed [VALUE_WIDTH-1:0] reduced_second;

  modport source (output valid, output reduced_first, output reduced_second, input ready);
  modport sink   (input valid, input reduced_first, input reduced_second, output ready);
endinterface

// ----- sv/fcfr_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcfr_datapath
// Binary gcd unit, two restoring dividers sharing the divisor, result regs.
// ----------------------------------------------------------------------------
module fcfr_datapath #(
  parameter int unsigned VALUE_WIDTH = fcfr_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  fcfr_pkg::cmd_t                cmd_i,
  input  logic signed [VALUE_WIDTH-1:0] first_value_i,
  input  logic signed [VALUE_WIDTH-1:0] second_value_i,
  output fcfr_pkg::status_t             status_o,
  output logic signed [VALUE_WIDTH-1:0] reduced_first_o,
  output logic signed [VALUE_WIDTH-1:0] reduced_second_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0] raw_a_q, raw_b_q;
  logic         neg_a_q, neg_b_q, bypass_q;
  logic [W-1:0] ga_q, ga_d, gb_q, gb_d;
  logic [CW-1:0] k_q, k_d, cnt_q, cnt_d;
  logic [W-1:0] g_q, g_d;
  logic [W-1:0] qa_q, qa_d, qb_q, qb_d;
  logic [W-1:0] ra_q, ra_d, rb_q, rb_d;
  logic [W-1:0] res_a_q, res_a_d, res_b_q, res_b_d;

  logic [W-1:0] in_a, in_b, mag_a, mag_b;
  logic         in_neg_a, in_neg_b, in_bypass;
  logic [W:0]   trial_a, trial_b, diff_a, diff_b;
  logic [W-1:0] join_a, join_b;
  logic         out_neg_a, out_neg_b;

  // sign and magnitude split of the incoming pair
  always_comb begin
    in_a      = first_value_i;
    in_b      = second_value_i;
    in_neg_a  = in_a[W-1];
    in_neg_b  = in_b[W-1];
    mag_a     = in_neg_a ? (~in_a + W'(1)) : in_a;
    mag_b     = in_neg_b ? (~in_b + W'(1)) : in_b;
    in_bypass = (mag_a == '0) || (mag_b == '0) || (in_a == W'(1)) || (in_b == W'(1));
  end

  // restoring division trial subtracts
  always_comb begin
    trial_a = {ra_q, qa_q[W-1]};
    trial_b = {rb_q, qb_q[W-1]};
    diff_a  = trial_a - {1'b0, g_q};
    diff_b  = trial_b - {1'b0, g_q};
  end

  // sign rebuild with positive saturation
  always_comb begin
    out_neg_a = neg_a_q && !neg_b_q;
    out_neg_b = neg_b_q && !neg_a_q;
    if (out_neg_a) begin
      join_a = ~qa_q + W'(1);
    end else if (qa_q[W-1]) begin
      join_a = {1'b0, {(W-1){1'b1}}};
    end else begin
      join_a = qa_q;
    end
    if (out_neg_b) begin
      join_b = ~qb_q + W'(1);
    end else if (qb_q[W-1]) begin
      join_b = {1'b0, {(W-1){1'b1}}};
    end else begin
      join_b = qb_q;
    end
  end

  always_comb begin
    ga_d    = ga_q;
    gb_d    = gb_q;
    k_d     = k_q;
    g_d     = g_q;
    cnt_d   = cnt_q;
    qa_d    = qa_q;
    qb_d    = qb_q;
    ra_d    = ra_q;
    rb_d    = rb_q;
    res_a_d = res_a_q;
    res_b_d = res_b_q;
    if (cmd_i.load) begin
      ga_d = mag_a;
      gb_d = mag_b;
      k_d  = '0;
      qa_d = mag_a;
      qb_d = mag_b;
    end
    if (cmd_i.gcd_step) begin
      if (!ga_q[0] && !gb_q[0]) begin
        ga_d = ga_q >> 1;
        gb_d = gb_q >> 1;
        k_d  = k_q + CW'(1);
      end else if (!ga_q[0]) begin
        ga_d = ga_q >> 1;
      end else if (!gb_q[0]) begin
        gb_d = gb_q >> 1;
      end else if (ga_q > gb_q) begin
        ga_d = ga_q - gb_q;
      end else begin
        gb_d = gb_q - ga_q;
      end
    end
    if (cmd_i.make_g) begin
      g_d   = ga_q << k_q;
      cnt_d = '0;
      ra_d  = '0;
      rb_d  = '0;
    end
    if (cmd_i.div_step) begin
      cnt_d = cnt_q + CW'(1);
      if (!diff_a[W]) begin
        ra_d = diff_a[W-1:0];
      end else begin
        ra_d = trial_a[W-1:0];
      end
      if (!diff_b[W]) begin
        rb_d = diff_b[W-1:0];
      end else begin
        rb_d = trial_b[W-1:0];
      end
      qa_d = {qa_q[W-2:0], ~diff_a[W]};
      qb_d = {qb_q[W-2:0], ~diff_b[W]};
    end
    if (cmd_i.store) begin
      res_a_d = bypass_q ? raw_a_q : join_a;
      res_b_d = bypass_q ? raw_b_q : join_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      raw_a_q  <= in_a;
      raw_b_q  <= in_b;
      neg_a_q  <= in_neg_a;
      neg_b_q  <= in_neg_b;
      bypass_q <= in_bypass;
    end
    ga_q    <= ga_d;
    gb_q    <= gb_d;
    k_q     <= k_d;
    g_q     <= g_d;
    cnt_q   <= cnt_d;
    qa_q    <= qa_d;
    qb_q    <= qb_d;
    ra_q    <= ra_d;
    rb_q    <= rb_d;
    res_a_q <= res_a_d;
    res_b_q <= res_b_d;
  end

  assign status_o.bypass   = bypass_q;
  assign status_o.gcd_done = (ga_q == gb_q);
  assign status_o.div_last = (cnt_q == CW'(W - 1));
  assign reduced_first_o   = res_a_q;
  assign reduced_second_o  = res_b_q;

endmodule

// ----- sv/fcfr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcfr_ctrl
// Sequencer: load, gcd iterations, divisor build, division steps, store.
// ----------------------------------------------------------------------------
module fcfr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  fcfr_pkg::status_t status_i,
  output fcfr_pkg::cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_GCD   = 5'b00010,
    ST_MAKEG = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_FIN   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_GCD;
        end
      end
      ST_GCD: begin
        if (status_i.bypass) begin
          state_d = ST_FIN;
        end else if (status_i.gcd_done) begin
          state_d = ST_MAKEG;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      ST_MAKEG: begin
        cmd_o.make_g = 1'b1;
        state_d      = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.store = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output word slot
  always_comb begin
    if (cmd_o.store) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/fraction_common_factor_reducer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_common_factor_reducer_top
// Divides a signed value pair by the gcd of the magnitudes.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries a word of first_value and second_value; out_o returns one
//   word of reduced_first and reduced_second for each accepted input word.
//   Both values are divided by gcd(|a|,|b|); when both are negative the
//   sign cancels too. A zero operand or an operand of exactly +1 passes the
//   pair through unchanged. A positive result of 2^(W-1) saturates.
// Sequencing:
//   one word at a time. Pass-through words skip the gcd, divisor and
//   division steps and go from load to store. Others take a load step,
//   binary gcd steps until both values match (one shift or subtract per
//   cycle), a divisor step and VALUE_WIDTH restoring division steps (both
//   quotients side by side), plus a store step.
// Reset:
//   rst_ni clears the sequencer and the output valid flag.
// Stall:
//   a finished word sits in the output register while the next input word is
//   accepted and worked on; the block waits only if a second result is ready
//   before the first one is taken.
// ----------------------------------------------------------------------------
module fraction_common_factor_reducer_top #(
  parameter int unsigned VALUE_WIDTH = fcfr_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fcfr_in_if.sink     in_i,
  fcfr_out_if.source  out_o
);

  fcfr_pkg::cmd_t    cmd;
  fcfr_pkg::status_t status;

  fcfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fcfr_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .first_value_i    (in_i.first_value),
    .second_value_i   (in_i.second_value),
    .status_o         (status),
    .reduced_first_o  (out_o.reduced_first),
    .reduced_second_o (out_o.reduced_second)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while a word is in progress");

  a_store_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.store |=> out_o.valid)
    else $error("stored result not presented");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.store |-> (!out_o.valid || out_o.ready))
    else $error("pending result overwritten");

  a_single_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("conflicting datapath commands");
`endif

endmodule

// ----- sim/tb_fraction_common_factor_reducer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fraction_common_factor_reducer_top
// Sends signed value pairs through the reducer and checks each returned word
// against a typed-in or gcd-based prediction. It starts with a table of corner cases,
// then moves to random pairs built with shared factors, full-range noise,
// small values and corner operands. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_fraction_common_factor_reducer_top;

  localparam int unsigned W           = fcfr_pkg::VALUE_WIDTH_DEF;
  localparam int          RANDOM_ITEMS = 1950;
  localparam int          QUIET_TAIL   = 200;
  localparam int          STALL_LIMIT  = 4000;
  localparam int          DRAIN_CYCLES = 6 * W;
  localparam int          PRINT_CAP    = 200;

  typedef logic [W-1:0] word_t;

  typedef struct packed {
    word_t first;
    word_t second;
  } pair_t;

  typedef struct {
    bit    typed;
    pair_t want;
  } note_t;

  typedef struct {
    pair_t operands;
    pair_t want;
  } due_t;

  typedef struct {
    int a;
    int b;
    bit typed;
    int ea;
    int eb;
  } row_t;

  // corner table, expected value typed in where it is obvious
  localparam int ROWS = 24;
  row_t corner_rows [ROWS] = '{
    '{0, 0, 1'b1, 0, 0},
    '{0, -7, 1'b1, 0, -7},
    '{12, 0, 1'b1, 12, 0},
    '{1, 2147483647, 1'b1, 1, 2147483647},
    '{-2147483647, 1, 1'b1, -2147483647, 1},
    '{-1, 5, 1'b0, 0, 0},
    '{-1, -1, 1'b1, 1, 1},
    '{6, 4, 1'b0, 0, 0},
    '{-6, 4, 1'b0, 0, 0},
    '{6, -4, 1'b0, 0, 0},
    '{-6, -4, 1'b0, 0, 0},
    '{2147483647, 2147483647, 1'b1, 1, 1},
    '{-2147483647, -2147483647, 1'b1, 1, 1},
    '{32'h8000_0000, 2, 1'b0, 0, 0},
    '{32'h8000_0000, -2, 1'b0, 0, 0},
    '{32'h8000_0000, 32'h8000_0000, 1'b1, 1, 1},
    '{32'h8000_0000, -1, 1'b1, 2147483647, 1},
    '{32'h8000_0000, 3, 1'b0, 0, 0},
    '{2147483647, 32'h8000_0000, 1'b0, 0, 0},
    '{1, 0, 1'b1, 1, 0},
    '{-1, 0, 1'b1, -1, 0},
    '{1073741824, 65536, 1'b0, 0, 0},
    '{2147483646, 1073741823, 1'b0, 0, 0},
    '{-1, 1, 1'b1, -1, 1}
  };

  logic clk_i;
  logic rst_ni;

  fcfr_in_if  #(.VALUE_WIDTH(W)) in_if  ();
  fcfr_out_if #(.VALUE_WIDTH(W)) out_if ();

  fraction_common_factor_reducer_top #(
    .VALUE_WIDTH(W)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  note_t pair_notes  [$];
  due_t  reduced_due [$];
  int    mismatches;
  int    quiet_cycles;
  int    idle_rate;
  bit    quiet_tail;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic word_t join_signed(logic neg, word_t mag);
    word_t max_pos;
    max_pos = {1'b0, {(W-1){1'b1}}};
    if (neg) return -mag;
    if (mag > max_pos) return max_pos;
    return mag;
  endfunction

  function automatic pair_t reduce_pair(word_t a, word_t b);
    logic  neg_a, neg_b, both_neg;
    word_t mag_a, mag_b, x, y, t;
    neg_a = a[W-1];
    neg_b = b[W-1];
    mag_a = neg_a ? -a : a;
    mag_b = neg_b ? -b : b;
    if (mag_a == '0 || mag_b == '0 || (!neg_a && mag_a == word_t'(1)) ||
        (!neg_b && mag_b == word_t'(1)))
      return '{first: a, second: b};
    x = mag_a;
    y = mag_b;
    while (y != '0) begin
      t = x % y;
      x = y;
      y = t;
    end
    both_neg = neg_a && neg_b;
    return '{first: join_signed(neg_a && !both_neg, mag_a / x),
             second: join_signed(neg_b && !both_neg, mag_b / x)};
  endfunction

  function automatic word_t corner_value();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return word_t'(1);
      2:       return '1;
      3:       return {1'b0, {(W-1){1'b1}}};
      4:       return {1'b1, {(W-2){1'b0}}, 1'b1};
      5:       return {1'b1, {(W-1){1'b0}}};
      default: return word_t'($urandom_range(2, 64));
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_pair(word_t a, word_t b, bit typed, pair_t want);
    note_t note;
    if (!quiet_tail && idle_rate != 0 && $urandom_range(0, 7) < idle_rate) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    note.typed = typed;
    note.want  = want;
    pair_notes.insert(pair_notes.size(), note);
    in_if.valid        <= 1'b1;
    in_if.first_value  <= a;
    in_if.second_value <= b;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pair_notes.size() != 0 || reduced_due.size() != 0) @(posedge clk_i);
  endtask

  // input monitor: prediction at each accepted word
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      note_t note;
      pair_t operands;
      due_t  entry;
      operands = '{first: in_if.first_value, second: in_if.second_value};
      if (pair_notes.size() == 0) begin
        report_mismatch("input word accepted with no stimulus record");
      end else begin
        note = pair_notes.pop_front();
        entry.operands = operands;
        entry.want     = note.typed ? note.want
                                    : reduce_pair(operands.first, operands.second);
        reduced_due.insert(reduced_due.size(), entry);
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      due_t due;
      if (reduced_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result word (%0d, %0d)",
                                  out_if.reduced_first, out_if.reduced_second));
      end else begin
        due = reduced_due.pop_front();
        if (out_if.reduced_first !== due.want.first)
          report_mismatch($sformatf("reduced_first %0d, want %0d for (%0d, %0d)",
                                    out_if.reduced_first, $signed(due.want.first),
                                    $signed(due.operands.first),
                                    $signed(due.operands.second)));
        if (out_if.reduced_second !== due.want.second)
          report_mismatch($sformatf("reduced_second %0d, want %0d for (%0d, %0d)",
                                    out_if.reduced_second, $signed(due.want.second),
                                    $signed(due.operands.first),
                                    $signed(due.operands.second)));
      end
    end
  end

  // progress counter for the watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    quiet_cycles = 0;
    @(posedge clk_i);
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // result sink with random stall bursts
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  end

  initial begin
    int unsigned       kind, kg, kx, ky;
    longint unsigned   g, x, y;
    word_t             a, b;
    pair_t             want;

    mismatches         = 0;
    quiet_tail         = 1'b0;
    idle_rate          = 2;
    rst_ni             = 1'b0;
    in_if.valid        <= 1'b0;
    in_if.first_value  <= '0;
    in_if.second_value <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_rows[i]) begin
      want = '{first: word_t'(corner_rows[i].ea), second: word_t'(corner_rows[i].eb)};
      send_pair(word_t'(corner_rows[i].a), word_t'(corner_rows[i].b),
                corner_rows[i].typed, want);
    end
    hold_until_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) idle_rate = $urandom_range(0, 3);
      if (n == RANDOM_ITEMS / 2) hold_until_drained();
      if (n == RANDOM_ITEMS - QUIET_TAIL) quiet_tail = 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        // shared factor times two cofactors
        kg = $urandom_range(1, 24);
        g  = $urandom & ((64'd1 << kg) - 1);
        if (g == 0) g = 1;
        kx = $urandom_range(1, 31 - kg);
        ky = $urandom_range(1, 31 - kg);
        x  = $urandom & ((64'd1 << kx) - 1);
        y  = $urandom & ((64'd1 << ky) - 1);
        a  = word_t'(g * x);
        b  = word_t'(g * y);
        if ($urandom_range(0, 1)) a = -a;
        if ($urandom_range(0, 1)) b = -b;
      end else if (kind < 70) begin
        a = $urandom;
        b = $urandom;
      end else if (kind < 88) begin
        a = word_t'(int'($urandom_range(0, 200)) - 100);
        b = word_t'(int'($urandom_range(0, 200)) - 100);
      end else begin
        a = corner_value();
        b = $urandom_range(0, 1) ? corner_value() : word_t'($urandom);
        if ($urandom_range(0, 1)) begin
          x = a;
          a = b;
          b = word_t'(x);
        end
      end
      send_pair(a, b, 1'b0, '0);
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (reduced_due.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", reduced_due.size()));
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
